>>> rtl/wsp_pkg.sv
package wsp_pkg;

  localparam int PT_W   = 24;
  localparam int PIX_W  = 24;
  localparam int VP_W   = 14;
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  // register index, paddr[5:3]
  localparam logic [2:0] REG_ROW0   = 3'd0;
  localparam logic [2:0] REG_ROW1   = 3'd1;
  localparam logic [2:0] REG_ROW2   = 3'd2;
  localparam logic [2:0] REG_ROW3   = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [63:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [63:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [63:0] ROW3_RST = 64'h1000_0000_0000_0000;
  localparam logic [VP_W-1:0] WIDTH_RST  = 14'd640;
  localparam logic [VP_W-1:0] HEIGHT_RST = 14'd480;

  localparam logic signed [PIX_W-1:0] PIX_MAX = 24'sh7FFFFF;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 24'sh800000;

  localparam int QBITS = 24;

  typedef logic signed [15:0] coef_t;
  typedef logic signed [39:0] prod_t;

endpackage

>>> rtl/wsp_in_if.sv
interface wsp_in_if
  import wsp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [PT_W-1:0]  point_x;
  logic signed [PT_W-1:0]  point_y;
  logic signed [PT_W-1:0]  point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

>>> rtl/wsp_out_if.sv
interface wsp_out_if
  import wsp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                    w_was_zero;
  logic                    clipped_range;

  modport source (output valid, pixel_x, pixel_y, w_was_zero, clipped_range, input ready);
  modport sink   (input valid, pixel_x, pixel_y, w_was_zero, clipped_range, output ready);
endinterface

>>> rtl/world_to_screen_projection_unit.sv
// Pipeline: 3 arithmetic stages, a rounding stage, 24 restoring divide stages
// one quotient bit each, output register.
// Throughput: one word per cycle; every stage holds its word while the next one is full.
// Reset (rst_n low, synchronous): pipeline emptied, matrix set to identity,
// viewport set to 640 x 480.
module world_to_screen_projection_unit
  import wsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  wsp_in_if.sink            in_chan,
  wsp_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int NST = 28;  // prod, sum, num, then divide entries 0..24

  // ---------------- configuration ----------------
  logic [63:0]     row0_r, row1_r, row2_r, row3_r;
  logic [VP_W-1:0] wd_r, ht_r;
  logic [2:0]      cfg_idx;
  logic            cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= ROW0_RST;
      row1_r <= ROW1_RST;
      row2_r <= ROW2_RST;
      row3_r <= ROW3_RST;
      wd_r   <= WIDTH_RST;
      ht_r   <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROW0:   row0_r <= pwdata;
        REG_ROW1:   row1_r <= pwdata;
        REG_ROW2:   row2_r <= pwdata;
        REG_ROW3:   row3_r <= pwdata;
        REG_WIDTH:  wd_r   <= pwdata[VP_W-1:0];
        REG_HEIGHT: ht_r   <= pwdata[VP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROW0:   prdata = row0_r;
      REG_ROW1:   prdata = row1_r;
      REG_ROW2:   prdata = row2_r;
      REG_ROW3:   prdata = row3_r;
      REG_WIDTH:  prdata = 64'(wd_r);
      REG_HEIGHT: prdata = 64'(ht_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic [NST-1:0] vld_r;
  logic [NST:0]   en;
  logic           out_valid_r;

  always_comb begin
    en[NST] = !out_valid_r || out_chan.ready;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_chan.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_chan.valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // ---------------- stage 0: products ----------------
  prod_t px_r [3][4];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 4; c++) begin
        px_r[0][c] <= (c == 3) ? prod_t'(coef_t'(row0_r[48 +: 16])) <<< 8 :
                      prod_t'(coef_t'(row0_r[16*c +: 16]) *
                              (c == 0 ? in_chan.point_x : c == 1 ? in_chan.point_y
                                                                 : in_chan.point_z));
        px_r[1][c] <= (c == 3) ? prod_t'(coef_t'(row1_r[48 +: 16])) <<< 8 :
                      prod_t'(coef_t'(row1_r[16*c +: 16]) *
                              (c == 0 ? in_chan.point_x : c == 1 ? in_chan.point_y
                                                                 : in_chan.point_z));
        px_r[2][c] <= (c == 3) ? prod_t'(coef_t'(row3_r[48 +: 16])) <<< 8 :
                      prod_t'(coef_t'(row3_r[16*c +: 16]) *
                              (c == 0 ? in_chan.point_x : c == 1 ? in_chan.point_y
                                                                 : in_chan.point_z));
      end
    end
  end

  // ---------------- stage 1: clip sums (Q.20) ----------------
  logic signed [41:0] cx_r, cy_r, cw_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cx_r <= 42'(px_r[0][0]) + 42'(px_r[0][1]) + 42'(px_r[0][2]) + 42'(px_r[0][3]);
      cy_r <= 42'(px_r[1][0]) + 42'(px_r[1][1]) + 42'(px_r[1][2]) + 42'(px_r[1][3]);
      cw_r <= 42'(px_r[2][0]) + 42'(px_r[2][1]) + 42'(px_r[2][2]) + 42'(px_r[2][3]);
    end
  end

  // ---------------- stage 2: numerators and divisor ----------------
  localparam logic signed [42:0] ONE_Q20 = 43'sd1048576;
  localparam logic signed [41:0] DEN_WZ  = 42'sd8192;

  logic               wz;
  logic signed [42:0] ax, ay;
  logic signed [57:0] mx, my;
  logic signed [63:0] numx_r, numy_r;
  logic signed [41:0] den_r;
  logic               wz_r;

  always_comb begin
    wz = (cw_r == '0);
    ax = wz ? 43'(cx_r) + ONE_Q20 : 43'(cx_r) + 43'(cw_r);
    ay = wz ? ONE_Q20 - 43'(cy_r) : 43'(cw_r) - 43'(cy_r);
    mx = ax * $signed({1'b0, wd_r});
    my = ay * $signed({1'b0, ht_r});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      numx_r <= wz ? 64'(mx) : {mx[56:0], 7'b0};
      numy_r <= wz ? 64'(my) : {my[56:0], 7'b0};
      den_r  <= wz ? DEN_WZ : cw_r;
      wz_r   <= wz;
    end
  end

  // ---------------- divide pipeline ----------------
  logic [63:0]       remx_r [QBITS];
  logic [63:0]       remy_r [QBITS];
  logic [41:0]       ad_r   [QBITS];
  logic [QBITS-1:0]  qx_r   [QBITS+1];
  logic [QBITS-1:0]  qy_r   [QBITS+1];
  logic [QBITS:0]    negx_r, negy_r, ovfx_r, ovfy_r, wzd_r;

  // entry 0: magnitudes, half-divisor bias for rounding, quotient range check
  logic [63:0] anx, any_v;
  logic [41:0] ad0;

  always_comb begin
    ad0   = den_r[41] ? 42'(-den_r) : 42'(den_r);
    anx   = (numx_r[63] ? 64'(-numx_r) : 64'(numx_r)) + 64'(ad0 >> 1);
    any_v = (numy_r[63] ? 64'(-numy_r) : 64'(numy_r)) + 64'(ad0 >> 1);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      remx_r[0] <= anx;
      remy_r[0] <= any_v;
      ad_r[0]   <= ad0;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      negx_r[0] <= numx_r[63] ^ den_r[41];
      negy_r[0] <= numy_r[63] ^ den_r[41];
      ovfx_r[0] <= {2'b0, anx}   >= ({24'b0, ad0} << QBITS);
      ovfy_r[0] <= {2'b0, any_v} >= ({24'b0, ad0} << QBITS);
      wzd_r[0]  <= wz_r;
    end
  end

  for (genvar j = 1; j <= QBITS; j++) begin : g_div
    localparam int K = QBITS - j;
    logic [64:0]       trx, try_v;
    logic [QBITS-1:0]  qx_nxt, qy_nxt;

    always_comb begin
      trx   = {1'b0, remx_r[j-1]} - ({23'b0, ad_r[j-1]} << K);
      try_v = {1'b0, remy_r[j-1]} - ({23'b0, ad_r[j-1]} << K);
      qx_nxt    = qx_r[j-1];
      qy_nxt    = qy_r[j-1];
      qx_nxt[K] = !trx[64];
      qy_nxt[K] = !try_v[64];
    end

    always_ff @(posedge clk) begin
      if (en[3+j]) begin
        qx_r[j]   <= qx_nxt;
        qy_r[j]   <= qy_nxt;
        negx_r[j] <= negx_r[j-1];
        negy_r[j] <= negy_r[j-1];
        ovfx_r[j] <= ovfx_r[j-1];
        ovfy_r[j] <= ovfy_r[j-1];
        wzd_r[j]  <= wzd_r[j-1];
      end
    end

    if (j < QBITS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[3+j]) begin
          remx_r[j] <= trx[64]   ? remx_r[j-1] : trx[63:0];
          remy_r[j] <= try_v[64] ? remy_r[j-1] : try_v[63:0];
          ad_r[j]   <= ad_r[j-1];
        end
      end
    end
  end

  // ---------------- output: sign and saturation ----------------
  logic                    satx, saty;
  logic signed [PIX_W-1:0] sx, sy;
  logic signed [PIX_W-1:0] pix_x_r, pix_y_r;
  logic                    wz_out_r, clip_r;

  always_comb begin
    satx = ovfx_r[QBITS] || (negx_r[QBITS] ? (qx_r[QBITS] > 24'h800000)
                                           : qx_r[QBITS][23]);
    saty = ovfy_r[QBITS] || (negy_r[QBITS] ? (qy_r[QBITS] > 24'h800000)
                                           : qy_r[QBITS][23]);
    if (satx)                sx = negx_r[QBITS] ? PIX_MIN : PIX_MAX;
    else if (negx_r[QBITS])  sx = -$signed(qx_r[QBITS]);
    else                     sx = $signed(qx_r[QBITS]);
    if (saty)                sy = negy_r[QBITS] ? PIX_MIN : PIX_MAX;
    else if (negy_r[QBITS])  sy = -$signed(qy_r[QBITS]);
    else                     sy = $signed(qy_r[QBITS]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en[NST]) begin
      out_valid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      pix_x_r  <= sx;
      pix_y_r  <= sy;
      wz_out_r <= wzd_r[QBITS];
      clip_r   <= satx || saty;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pixel_x       = pix_x_r;
  assign out_chan.pixel_y       = pix_y_r;
  assign out_chan.w_was_zero    = wz_out_r;
  assign out_chan.clipped_range = clip_r;

  // ---------------- assertions ----------------
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("output valid right after reset");

  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.clipped_range |->
      (out_chan.pixel_x == PIX_MAX || out_chan.pixel_x == PIX_MIN ||
       out_chan.pixel_y == PIX_MAX || out_chan.pixel_y == PIX_MIN))
    else $error("saturation flag without a saturated coordinate");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (vld_r[0] && out_chan.valid && !out_chan.ready))
    else $error("input stalled with room in the pipeline");

endmodule
